/* hw/rtl/planar_tile_sprite_blitter_assert.svh */
// Assertion helpers shared by the blitter modules.
// Each expects aclk and aresetn to be in scope.
`ifndef PLANAR_TILE_SPRITE_BLITTER_ASSERT_SVH
`define PLANAR_TILE_SPRITE_BLITTER_ASSERT_SVH

// Same-cycle implication.
`define PTSB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ptsb_pkg.sv */
`timescale 1ns / 1ps
package ptsb_pkg;

    localparam int COORD_BITS     = 12;
    localparam int XY_BITS        = 13;
    localparam int LANES          = 8;
    localparam int LANE_IDX_BITS  = $clog2(LANES);
    localparam int LINE_BITS      = 3;
    localparam int TILE_BITS      = 8;
    localparam int MODE_BITS      = 4;
    localparam int COLOR_BITS     = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;
    localparam int IN_DATA_BITS   = 16;
    localparam int OUT_DATA_BITS  = 32;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - 2 * XY_BITS - COLOR_BITS;

    localparam logic [LINE_BITS-1:0] LINE_LAST = LINE_BITS'(LANES - 1);

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_TILES  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_TILES = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_MODE   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TWO_PLANE    = 3'd5;

    // Blend modes that let color zero through as a hole
    localparam logic [MODE_BITS-1:0] MODE_CLEAR_A = 4'h0;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR_B = 4'h5;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR_C = 4'ha;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR_D = 4'hf;

    localparam logic [COLOR_BITS-1:0] BLEND_LUT [4][16] = '{
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
          2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
        '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
          2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
          2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
        '{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
          2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}
    };

    typedef struct packed {
        logic                  draw;
        logic [COLOR_BITS-1:0] color;
    } lane_out_t;

    typedef struct packed {
        logic [XY_BITS-1:0] x_base;
        logic [XY_BITS-1:0] y;
    } pos_t;

    function automatic logic is_transparent(input logic [MODE_BITS-1:0] mode);
        return mode inside {MODE_CLEAR_A, MODE_CLEAR_B, MODE_CLEAR_C, MODE_CLEAR_D};
    endfunction

    function automatic logic [COLOR_BITS-1:0] blend_lookup(
        input logic [COLOR_BITS-1:0] color,
        input logic [MODE_BITS-1:0]  mode
    );
        return BLEND_LUT[color][mode];
    endfunction

endpackage

/* hw/rtl/planar_tile_sprite_blitter.sv */
`timescale 1ns / 1ps
// Each accepted word is registered in the merge stage, then its drawn pixels move to the output
// register in turn, leftmost first, one pixel per cycle while m_tready does not stall the output.
// A new word is taken only when no pixels are pending or the last pending pixel pops.
// Words with no drawn pixel leave the merge stage free and produce no output.
// Reset (aresetn low at a clock edge): counters, pending pixels and output valid clear,
// registers return to origin 0,0, size 1x1 tiles, blend mode 1, two-plane mode on.
module planar_tile_sprite_blitter
    import ptsb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,   // low_plane[7:0], high_plane[15:8]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,   // pixel_x[12:0], pixel_y[25:13],
                                                 // pixel_color[27:26], zero[31:28]
    output logic                      m_tlast
);

    logic [COORD_BITS-1:0] origin_x_reg, origin_y_reg;
    logic [TILE_BITS-1:0]  width_reg, height_reg;
    logic [MODE_BITS-1:0]  mode_reg;
    logic                  two_plane_reg;

    logic                  accept;
    logic                  in_ready;
    pos_t                  pos;
    lane_out_t [LANES-1:0] lanes;
    logic [7:0]            low_plane, high_plane;
    logic [XY_BITS-1:0]    px, py;
    logic [COLOR_BITS-1:0] pcolor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            width_reg     <= TILE_BITS'(1);
            height_reg    <= TILE_BITS'(1);
            mode_reg      <= MODE_BITS'(1);
            two_plane_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg  <= cfg_data[COORD_BITS-1:0];
                REG_ORIGIN_Y:     origin_y_reg  <= cfg_data[COORD_BITS-1:0];
                REG_WIDTH_TILES:  width_reg     <= cfg_data[TILE_BITS-1:0];
                REG_HEIGHT_TILES: height_reg    <= cfg_data[TILE_BITS-1:0];
                REG_BLEND_MODE:   mode_reg      <= cfg_data[MODE_BITS-1:0];
                REG_TWO_PLANE:    two_plane_reg <= cfg_data[0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign s_tready   = in_ready;
    assign accept     = s_tvalid && in_ready;
    assign low_plane  = s_tdata[7:0];
    assign high_plane = s_tdata[15:8];

    ptsb_walk u_walk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .width_tiles  (width_reg),
        .height_tiles (height_reg),
        .pos          (pos)
    );

    // lane i handles the i-th pixel from the left, which is bit 7-i of each plane
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        ptsb_lane u_lane (
            .lo_bit     (low_plane[LANES-1-i]),
            .hi_bit     (high_plane[LANES-1-i]),
            .two_plane  (two_plane_reg),
            .blend_mode (mode_reg),
            .result     (lanes[i])
        );
    end

    ptsb_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .lanes     (lanes),
        .pos       (pos),
        .in_ready  (in_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (px),
        .out_y     (py),
        .out_color (pcolor),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{OUT_PAD_BITS{1'b0}}, pcolor, py, px};

endmodule

/* hw/rtl/ptsb_lane.sv */
`timescale 1ns / 1ps
module ptsb_lane
    import ptsb_pkg::*;
(
    input  logic                 lo_bit,
    input  logic                 hi_bit,
    input  logic                 two_plane,
    input  logic [MODE_BITS-1:0] blend_mode,
    output lane_out_t            result
);

    logic [COLOR_BITS-1:0] raw_color;

    assign raw_color    = two_plane ? {hi_bit, lo_bit} : {1'b0, lo_bit};
    assign result.draw  = !(is_transparent(blend_mode) && (raw_color == '0));
    assign result.color = blend_lookup(raw_color, blend_mode);

endmodule

/* hw/rtl/ptsb_walk.sv */
`timescale 1ns / 1ps
`include "planar_tile_sprite_blitter_assert.svh"
module ptsb_walk
    import ptsb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [COORD_BITS-1:0] origin_x,
    input  logic [COORD_BITS-1:0] origin_y,
    input  logic [TILE_BITS-1:0]  width_tiles,
    input  logic [TILE_BITS-1:0]  height_tiles,
    output pos_t                  pos
);

    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [TILE_BITS-1:0] col_reg, col_next;
    logic [TILE_BITS-1:0] row_reg, row_next;

    always_comb begin
        line_next = line_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (advance) begin
            if (line_reg != LINE_LAST) begin
                line_next = line_reg + 1'b1;
            end else begin
                line_next = '0;
                // widths of zero behave as one: the compare never passes
                if (({1'b0, col_reg} + 1'b1) < {1'b0, width_tiles}) begin
                    col_next = col_reg + 1'b1;
                end else begin
                    col_next = '0;
                    if (({1'b0, row_reg} + 1'b1) < {1'b0, height_tiles}) begin
                        row_next = row_reg + 1'b1;
                    end else begin
                        row_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            line_reg <= line_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    assign pos.x_base = XY_BITS'(origin_x) + XY_BITS'({col_reg, 3'b000});
    assign pos.y      = XY_BITS'(origin_y) + XY_BITS'({row_reg, 3'b000})
                      + XY_BITS'(line_reg);

    `PTSB_ASSERT_NEXT(a_walk_hold, !advance, $stable({line_reg, col_reg, row_reg}),
        "walk counters moved without an accepted word")
    `PTSB_ASSERT_NEXT(a_walk_line, advance && (line_reg != LINE_LAST),
        (line_reg == $past(line_reg) + 1'b1) && $stable(col_reg) && $stable(row_reg),
        "line step disturbed tile counters")

endmodule

/* hw/rtl/ptsb_merge.sv */
`timescale 1ns / 1ps
`include "planar_tile_sprite_blitter_assert.svh"
module ptsb_merge
    import ptsb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  lane_out_t [LANES-1:0]  lanes,
    input  pos_t                   pos,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [XY_BITS-1:0]     out_x,
    output logic [XY_BITS-1:0]     out_y,
    output logic [COLOR_BITS-1:0]  out_color,
    output logic                   out_last
);

    logic [LANES-1:0]                 mask_reg, mask_next, new_mask, rest_mask;
    logic [LANES-1:0][COLOR_BITS-1:0] color_reg;
    logic [XY_BITS-1:0]               x_base_reg, y_reg;
    logic                             valid_reg;
    logic [XY_BITS-1:0]               x_reg;
    logic [XY_BITS-1:0]               oy_reg;
    logic [COLOR_BITS-1:0]            ocolor_reg;
    logic                             last_reg;
    logic [LANE_IDX_BITS-1:0]         idx;
    logic                             out_free, pop, pop_last;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            new_mask[i] = lanes[i].draw;
        end
    end

    // leftmost pending pixel goes first
    always_comb begin
        idx = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (mask_reg[i]) idx = LANE_IDX_BITS'(i);
        end
    end

    assign rest_mask = mask_reg & ~(LANES'(1) << idx);
    assign out_free  = !valid_reg || out_ready;
    assign pop       = out_free && (mask_reg != '0);
    assign pop_last  = (rest_mask == '0);
    assign in_ready  = (mask_reg == '0) || (pop && pop_last);

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = new_mask;
        end else if (pop) begin
            mask_next = rest_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (pop) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < LANES; i++) begin
                color_reg[i] <= lanes[i].color;
            end
            x_base_reg <= pos.x_base;
            y_reg      <= pos.y;
        end
        if (pop) begin
            x_reg      <= x_base_reg + XY_BITS'(idx);
            oy_reg     <= y_reg;
            ocolor_reg <= color_reg[idx];
            last_reg   <= pop_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = oy_reg;
    assign out_color = ocolor_reg;
    assign out_last  = last_reg;

    `PTSB_ASSERT_NOW(a_merge_ready, mask_reg == '0, in_ready,
        "input stalled with no pixels pending")
    `PTSB_ASSERT_NEXT(a_merge_pop, pop, valid_reg,
        "popped pixel did not reach the output register")
    `PTSB_ASSERT_NEXT(a_merge_hold, (mask_reg != '0) && valid_reg && !out_ready,
        $stable(mask_reg), "pending pixels changed during output stall")
    `PTSB_ASSERT_NEXT(a_merge_count, pop && !load,
        $countones(mask_reg) == $countones($past(mask_reg)) - 1,
        "pop did not retire exactly one pixel")

endmodule
